// ----- rtl/tlvc_pkg.sv -----
// shared types, constants and arithmetic helpers for the tensor contraction block
package tlvc_pkg;

	localparam int MaxVectors = 1024;
	localparam int IdxW       = $clog2(MaxVectors);
	localparam int LenW       = 11;
	localparam int DataW      = 32;
	localparam int AccW       = 48;
	localparam int ProdW      = 2 * DataW;
	localparam int FracW      = 16;
	localparam int CfgIdxW    = 2;
	localparam int SliceW     = 2;

	// configuration register indexes
	localparam logic [CfgIdxW-1:0] RegCoeffFirst  = 2'd0;
	localparam logic [CfgIdxW-1:0] RegCoeffSecond = 2'd1;
	localparam logic [CfgIdxW-1:0] RegCoeffThird  = 2'd2;
	localparam logic [CfgIdxW-1:0] RegSliceLen    = 2'd3;

	// slice codes
	localparam logic [SliceW-1:0] SliceFirst  = 2'd0;
	localparam logic [SliceW-1:0] SliceSecond = 2'd1;
	localparam logic [SliceW-1:0] SliceThird  = 2'd2;

	typedef logic signed [DataW-1:0] data_t;
	typedef logic signed [AccW-1:0]  acc_t;
	typedef logic signed [ProdW-1:0] prod_t;
	typedef logic [IdxW-1:0]         idx_t;
	typedef logic [LenW-1:0]         len_t;
	typedef logic [SliceW-1:0]       slice_t;

	localparam data_t DataMax = {1'b0, {(DataW-1){1'b1}}};
	localparam data_t DataMin = {1'b1, {(DataW-1){1'b0}}};
	localparam acc_t  AccMax  = {1'b0, {(AccW-1){1'b1}}};
	localparam acc_t  AccMin  = {1'b1, {(AccW-1){1'b0}}};

	typedef struct packed {
		data_t coeff_first;
		data_t coeff_second;
		data_t coeff_third;
		len_t  slice_len;
	} cfg_t;

	typedef struct packed {
		data_t  x;
		data_t  y;
		data_t  z;
		data_t  coeff;
		idx_t   idx;
		slice_t slice;
		logic   last;
	} s1_t;

	typedef struct packed {
		acc_t x;
		acc_t y;
		acc_t z;
	} acc3_t;

	typedef struct packed {
		acc_t x;
		acc_t y;
		acc_t z;
		logic emit;
		logic last;
	} s3_t;

	// product in Q16.16, floor rounding; the value always fits the accumulator
	function automatic acc_t prod_q16(prod_t p);
		prod_q16 = acc_t'(p[ProdW-1:FracW]);
	endfunction

	// accumulator add with saturation to the accumulator range
	function automatic acc_t add_sat(acc_t a, acc_t b);
		logic [AccW:0] s;
		s = {a[AccW-1], a} + {b[AccW-1], b};
		if (s[AccW] != s[AccW-1]) begin
			add_sat = s[AccW] ? AccMin : AccMax;
		end else begin
			add_sat = acc_t'(s[AccW-1:0]);
		end
	endfunction

	// narrow an accumulator to the output width with saturation
	function automatic data_t sat_data(acc_t v);
		if ((&v[AccW-1:DataW-1]) || !(|v[AccW-1:DataW-1])) begin
			sat_data = data_t'(v[DataW-1:0]);
		end else begin
			sat_data = v[AccW-1] ? DataMin : DataMax;
		end
	endfunction

endpackage

// ----- rtl/tlvc_if.sv -----
// valid/ready stream interfaces for input vectors and result vectors
interface tlvc_in_if;
	logic                valid;
	logic                ready;
	tlvc_pkg::data_t     comp_x;
	tlvc_pkg::data_t     comp_y;
	tlvc_pkg::data_t     comp_z;

	modport source (output valid, output comp_x, output comp_y, output comp_z, input ready);
	modport sink   (input valid, input comp_x, input comp_y, input comp_z, output ready);
endinterface

interface tlvc_out_if;
	logic                valid;
	logic                ready;
	tlvc_pkg::data_t     out_x;
	tlvc_pkg::data_t     out_y;
	tlvc_pkg::data_t     out_z;
	logic                last_of_tensor;

	modport source (output valid, output out_x, output out_y, output out_z,
		output last_of_tensor, input ready);
	modport sink   (input valid, input out_x, input out_y, input out_z,
		input last_of_tensor, output ready);
endinterface

// ----- rtl/tlvc_cfg.sv -----
// configuration registers: slice weights and slice length
module tlvc_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [tlvc_pkg::CfgIdxW-1:0]  cfg_idx,
	input  logic [tlvc_pkg::DataW-1:0]    cfg_wdata,
	output tlvc_pkg::cfg_t                cfg
);

	tlvc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.coeff_first  <= '0;
			cfg_q.coeff_second <= '0;
			cfg_q.coeff_third  <= '0;
			cfg_q.slice_len    <= tlvc_pkg::len_t'(1);
		end else if (cfg_we) begin
			case (cfg_idx)
				tlvc_pkg::RegCoeffFirst:  cfg_q.coeff_first  <= tlvc_pkg::data_t'(cfg_wdata);
				tlvc_pkg::RegCoeffSecond: cfg_q.coeff_second <= tlvc_pkg::data_t'(cfg_wdata);
				tlvc_pkg::RegCoeffThird:  cfg_q.coeff_third  <= tlvc_pkg::data_t'(cfg_wdata);
				tlvc_pkg::RegSliceLen:    cfg_q.slice_len    <= cfg_wdata[tlvc_pkg::LenW-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- rtl/tlvc_front.sv -----
// input stage: slice/vector position tracking, weight select, first pipeline register
module tlvc_front (
	input  logic            clk,
	input  logic            arst_n,
	tlvc_in_if.sink         vec,
	input  tlvc_pkg::cfg_t  cfg,
	input  logic            ready_dn,
	output logic            v_s1,
	output tlvc_pkg::s1_t   d_s1
);

	tlvc_pkg::slice_t slice_q;
	tlvc_pkg::idx_t   vidx_q;
	tlvc_pkg::len_t   eff_len;
	tlvc_pkg::len_t   pos_next;
	tlvc_pkg::data_t  coeff_sel;
	logic             ready_s1;
	logic             take;
	logic             end_of_slice;

	assign ready_s1  = !v_s1 || ready_dn;
	assign vec.ready = ready_s1;
	assign take      = vec.valid && ready_s1;

	// zero counts as one, anything past the memory depth is clamped
	always_comb begin
		if (cfg.slice_len == '0) begin
			eff_len = tlvc_pkg::len_t'(1);
		end else if (cfg.slice_len > tlvc_pkg::len_t'(tlvc_pkg::MaxVectors)) begin
			eff_len = tlvc_pkg::len_t'(tlvc_pkg::MaxVectors);
		end else begin
			eff_len = cfg.slice_len;
		end
	end

	assign pos_next     = tlvc_pkg::len_t'(vidx_q) + tlvc_pkg::len_t'(1);
	assign end_of_slice = (pos_next >= eff_len);

	always_comb begin
		case (slice_q)
			tlvc_pkg::SliceFirst:  coeff_sel = cfg.coeff_first;
			tlvc_pkg::SliceSecond: coeff_sel = cfg.coeff_second;
			default:               coeff_sel = cfg.coeff_third;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slice_q <= tlvc_pkg::SliceFirst;
			vidx_q  <= '0;
		end else if (take) begin
			if (end_of_slice) begin
				vidx_q  <= '0;
				slice_q <= (slice_q == tlvc_pkg::SliceThird) ? tlvc_pkg::SliceFirst
					: slice_q + tlvc_pkg::slice_t'(1);
			end else begin
				vidx_q <= vidx_q + tlvc_pkg::idx_t'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (ready_s1) begin
			v_s1 <= vec.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			d_s1.x     <= vec.comp_x;
			d_s1.y     <= vec.comp_y;
			d_s1.z     <= vec.comp_z;
			d_s1.coeff <= coeff_sel;
			d_s1.idx   <= vidx_q;
			d_s1.slice <= slice_q;
			d_s1.last  <= end_of_slice;
		end
	end

endmodule

// ----- rtl/tlvc_accum.sv -----
// multiply stage and running-sum read/modify/write stage with the partial-sum memory
module tlvc_accum (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            v_s1,
	input  tlvc_pkg::s1_t   d_s1,
	output logic            ready_up,
	output logic            v_s3,
	output tlvc_pkg::s3_t   d_s3,
	input  logic            ready_dn
);

	tlvc_pkg::acc3_t  mem_q [tlvc_pkg::MaxVectors];

	logic             v_s2;
	tlvc_pkg::prod_t  prod_x_s2;
	tlvc_pkg::prod_t  prod_y_s2;
	tlvc_pkg::prod_t  prod_z_s2;
	tlvc_pkg::idx_t   idx_s2;
	tlvc_pkg::slice_t slice_s2;
	logic             last_s2;
	tlvc_pkg::acc3_t  rd_s2;
	tlvc_pkg::idx_t   idx_s3;

	logic             ready_s2;
	logic             ready_s3;
	tlvc_pkg::acc3_t  fwd;
	tlvc_pkg::acc3_t  prod;
	tlvc_pkg::acc3_t  sum;

	assign ready_s3 = !v_s3 || ready_dn;
	assign ready_s2 = !v_s2 || ready_s3;
	assign ready_up = ready_s2;

	// the item in s3 wrote its entry at or after the edge our read happened
	always_comb begin
		if (v_s3 && (idx_s3 == idx_s2)) begin
			fwd.x = d_s3.x;
			fwd.y = d_s3.y;
			fwd.z = d_s3.z;
		end else begin
			fwd = rd_s2;
		end
	end

	always_comb begin
		prod.x = tlvc_pkg::prod_q16(prod_x_s2);
		prod.y = tlvc_pkg::prod_q16(prod_y_s2);
		prod.z = tlvc_pkg::prod_q16(prod_z_s2);
		if (slice_s2 == tlvc_pkg::SliceFirst) begin
			sum = prod;
		end else begin
			sum.x = tlvc_pkg::add_sat(fwd.x, prod.x);
			sum.y = tlvc_pkg::add_sat(fwd.y, prod.y);
			sum.z = tlvc_pkg::add_sat(fwd.z, prod.z);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (ready_s2) begin
				v_s2 <= v_s1;
			end
			if (ready_s3) begin
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2) begin
			prod_x_s2 <= d_s1.x * d_s1.coeff;
			prod_y_s2 <= d_s1.y * d_s1.coeff;
			prod_z_s2 <= d_s1.z * d_s1.coeff;
			idx_s2    <= d_s1.idx;
			slice_s2  <= d_s1.slice;
			last_s2   <= d_s1.last;
		end
	end

	// read data register; while stalled it keeps tracking the newest sum
	always_ff @(posedge clk) begin
		if (ready_s2) begin
			rd_s2 <= mem_q[d_s1.idx];
		end else begin
			rd_s2 <= fwd;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s3 && v_s2) begin
			mem_q[idx_s2] <= sum;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s3) begin
			d_s3.x    <= sum.x;
			d_s3.y    <= sum.y;
			d_s3.z    <= sum.z;
			d_s3.emit <= (slice_s2 == tlvc_pkg::SliceThird);
			d_s3.last <= last_s2;
			idx_s3    <= idx_s2;
		end
	end

endmodule

// ----- rtl/tlvc_out.sv -----
// output register: narrows sums to 32 bits and drops items that give no result
module tlvc_out (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            v_s3,
	input  tlvc_pkg::s3_t   d_s3,
	output logic            ready_up,
	tlvc_out_if.source      res
);

	logic            v_s4;
	tlvc_pkg::data_t x_s4;
	tlvc_pkg::data_t y_s4;
	tlvc_pkg::data_t z_s4;
	logic            last_s4;

	assign ready_up = !v_s4 || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (ready_up) begin
			v_s4 <= v_s3 && d_s3.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_up && v_s3 && d_s3.emit) begin
			x_s4    <= tlvc_pkg::sat_data(d_s3.x);
			y_s4    <= tlvc_pkg::sat_data(d_s3.y);
			z_s4    <= tlvc_pkg::sat_data(d_s3.z);
			last_s4 <= d_s3.last;
		end
	end

	assign res.valid          = v_s4;
	assign res.out_x          = x_s4;
	assign res.out_y          = y_s4;
	assign res.out_z          = z_s4;
	assign res.last_of_tensor = last_s4;

endmodule

// ----- rtl/tensor_left_vector_contraction_top.sv -----
// Contracts the first index of a streamed rank d+1 tensor with a fixed Q16.16
// 3-vector. Vectors arrive slice by slice (slice_len vectors per slice, three
// slices per tensor); one result comes out for each vector of the third slice,
// saturated to 32 bits, with last_of_tensor on the final one. The block takes
// one vector per clock when the output is not held back; each vector passes
// through the input, product, sum and output registers in turn. The rate is set
// by the 1024 x 144 bit running-sum memory with one read and one write port,
// whose read/modify/write is spread over two stages with forwarding of the sum
// still in flight. The memory is not cleared after reset: the first slice of
// each tensor writes every entry that the later slices read. Configuration
// must be written only while idle; the block itself does not enforce this.
module tensor_left_vector_contraction_top (
	input  logic                          clk,
	input  logic                          arst_n,
	tlvc_in_if.sink                       vec,
	tlvc_out_if.source                    res,
	input  logic                          cfg_we,
	input  logic [tlvc_pkg::CfgIdxW-1:0]  cfg_idx,
	input  logic [tlvc_pkg::DataW-1:0]    cfg_wdata
);

	tlvc_pkg::cfg_t cfg;
	logic           v_s1;
	tlvc_pkg::s1_t  d_s1;
	logic           ready_s2;
	logic           v_s3;
	tlvc_pkg::s3_t  d_s3;
	logic           ready_s4;

	tlvc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	tlvc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.vec      (vec),
		.cfg      (cfg),
		.ready_dn (ready_s2),
		.v_s1     (v_s1),
		.d_s1     (d_s1)
	);

	tlvc_accum u_accum (
		.clk      (clk),
		.arst_n   (arst_n),
		.v_s1     (v_s1),
		.d_s1     (d_s1),
		.ready_up (ready_s2),
		.v_s3     (v_s3),
		.d_s3     (d_s3),
		.ready_dn (ready_s4)
	);

	tlvc_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.v_s3     (v_s3),
		.d_s3     (d_s3),
		.ready_up (ready_s4),
		.res      (res)
	);

endmodule

// ----- rtl/tlvc_chk.sv -----
// port-level checker for the contraction block, bound to the top level
module tlvc_chk (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        vec_ready,
	input logic                        res_valid,
	input logic                        res_ready,
	input logic [tlvc_pkg::DataW-1:0]  res_x,
	input logic                        res_last
);

	// a held result keeps its valid
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result valid dropped while stalled");

	// a held result keeps its payload
	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(res_x) && $stable(res_last))
		else $error("result payload changed while stalled");

	// the pipeline can only refuse input when the output is blocked
	a_ready_chain: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid || res_ready |-> vec_ready)
		else $error("input refused while output side is free");

	// leaving reset, the pipeline is empty and open
	a_reset_empty: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !res_valid && vec_ready)
		else $error("pipeline not empty after reset");

endmodule

bind tensor_left_vector_contraction_top tlvc_chk u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.vec_ready (vec.ready),
	.res_valid (res.valid),
	.res_ready (res.ready),
	.res_x     (res.out_x),
	.res_last  (res.last_of_tensor)
);

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// self-checking testbench for the tensor contraction top: stream stimulus, predictor, checker
module tb_top;
	import tlvc_pkg::*;

	localparam int unsigned RandomItems   = 200;
	localparam int unsigned DrainCycles   = 8;
	localparam int unsigned StallHold     = 200;
	localparam int unsigned WatchdogLimit = 2000;

	typedef struct packed {
		data_t x;
		data_t y;
		data_t z;
		logic  last;
	} result_t;

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [CfgIdxW-1:0]  cfg_idx;
	logic [DataW-1:0]    cfg_wdata;

	tlvc_in_if  vec_if ();
	tlvc_out_if res_if ();

	tensor_left_vector_contraction_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.vec       (vec_if),
		.res       (res_if),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	// contraction predictor state
	data_t       coef_first  = '0;
	data_t       coef_second = '0;
	data_t       coef_third  = '0;
	len_t        len_reg     = len_t'(1);
	longint      acc_mem [3][MaxVectors];
	slice_t      slice_pos   = SliceFirst;
	int unsigned vec_pos     = 0;
	result_t     pending_results [$];

	int unsigned mismatches  = 0;
	int unsigned items_sent  = 0;
	bit          send_idle   = 1'b1;
	bit          recv_idle   = 1'b1;
	bit          res_seen    = 1'b0;
	int unsigned hold_left   = 0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic longint scaled(data_t c, data_t v);
		longint p;
		p = longint'(c) * longint'(v);
		return p >>> FracW;
	endfunction

	function automatic longint clamp(longint v, longint lo, longint hi);
		if (v > hi) return hi;
		if (v < lo) return lo;
		return v;
	endfunction

	function automatic int unsigned eff_len();
		if (len_reg == 0) return 1;
		if (len_reg > MaxVectors) return MaxVectors;
		return len_reg;
	endfunction

	function automatic bit at_tensor_start();
		return slice_pos == SliceFirst && vec_pos == 0;
	endfunction

	function automatic void predict_vector(data_t x, data_t y, data_t z);
		data_t       lane_in [3];
		data_t       lane_out [3];
		int unsigned row;
		bit          slice_end;
		lane_in = '{x, y, z};
		row = (vec_pos >= MaxVectors) ? MaxVectors - 1 : vec_pos;
		slice_end = (vec_pos + 1 >= eff_len());
		for (int l = 0; l < 3; l++) begin
			case (slice_pos)
				SliceFirst: begin
					acc_mem[l][row] = scaled(coef_first, lane_in[l]);
				end
				SliceSecond: begin
					acc_mem[l][row] = clamp(acc_mem[l][row] + scaled(coef_second, lane_in[l]),
						AccMin, AccMax);
				end
				default: begin
					acc_mem[l][row] = clamp(acc_mem[l][row] + scaled(coef_third, lane_in[l]),
						AccMin, AccMax);
				end
			endcase
			lane_out[l] = data_t'(clamp(acc_mem[l][row], DataMin, DataMax));
		end
		if (slice_pos == SliceThird) begin
			pending_results.push_back('{lane_out[0], lane_out[1], lane_out[2], slice_end});
		end
		if (slice_end) begin
			vec_pos = 0;
			slice_pos = (slice_pos == SliceThird) ? SliceFirst : slice_t'(slice_pos + 1);
		end else begin
			vec_pos++;
		end
	endfunction

	function automatic data_t random_word();
		case ($urandom_range(0, 9))
			0: return DataMax;
			1: return DataMin;
			2: return '0;
			3: return data_t'(-1);
			4, 5: return data_t'($urandom_range(0, 32'h0008_0000)) - data_t'(32'sh0004_0000);
			default: return data_t'($urandom);
		endcase
	endfunction

	// upper bits of the write data are junk on purpose, only the low bits count
	function automatic logic [DataW-1:0] random_len();
		logic [DataW-1:0] v;
		v = $urandom;
		case ($urandom_range(0, 9))
			0: v[LenW-1:0] = '0;
			1, 2: v[LenW-1:0] = len_t'($urandom_range(7, 40));
			default: v[LenW-1:0] = len_t'($urandom_range(1, 6));
		endcase
		return v;
	endfunction

	task automatic report_error(input string msg);
		$display("ERROR at %0t: %s", $time, msg);
		mismatches++;
	endtask

	task automatic compare_field(input string name, input logic [DataW-1:0] got,
		input logic [DataW-1:0] want);
		if (got !== want) begin
			report_error($sformatf("%s got %h expected %h", name, got, want));
		end
	endtask

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [DataW-1:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= value;
		case (idx)
			RegCoeffFirst:  coef_first  = data_t'(value);
			RegCoeffSecond: coef_second = data_t'(value);
			RegCoeffThird:  coef_third  = data_t'(value);
			RegSliceLen:    len_reg     = value[LenW-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_coeffs(input data_t c1, input data_t c2, input data_t c3);
		write_reg(RegCoeffFirst, c1);
		write_reg(RegCoeffSecond, c2);
		write_reg(RegCoeffThird, c3);
	endtask

	task automatic send_vector(input data_t x, input data_t y, input data_t z);
		int unsigned gap;
		gap = send_idle ? $urandom_range(0, 12) : 0;
		@(negedge clk);
		if (gap > 0) begin
			vec_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		vec_if.valid  <= 1'b1;
		vec_if.comp_x <= x;
		vec_if.comp_y <= y;
		vec_if.comp_z <= z;
		do @(posedge clk); while (!vec_if.ready);
		predict_vector(x, y, z);
		items_sent++;
	endtask

	task automatic stream_vectors(input int unsigned count);
		repeat (count) send_vector(random_word(), random_word(), random_word());
	endtask

	task automatic finish_tensor();
		while (!at_tensor_start()) stream_vectors(1);
	endtask

	// no results outstanding and the pipeline has had time to retire non-emitting vectors
	task automatic drain();
		@(negedge clk);
		vec_if.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic test_reset_state();
		// reset weights are zero and slices are one vector long
		stream_vectors(3);
	endtask

	task automatic test_extremes();
		drain();
		write_reg(RegSliceLen, 1);
		set_coeffs(DataMin, DataMin, DataMin);
		send_vector(DataMin, DataMax, '0);
		send_vector(DataMin, DataMax, data_t'(-1));
		send_vector(DataMin, DataMax, data_t'(1));
		drain();
		// sum saturates at 48 bits before the third slice pulls it back
		set_coeffs(DataMin, DataMin, DataMax);
		send_vector(DataMin, DataMax, DataMin);
		send_vector(DataMin, DataMax, DataMin);
		send_vector(DataMin, DataMin, DataMax);
		drain();
		set_coeffs(data_t'(32'sh0001_0000), data_t'(32'shFFFF_0000), DataMax);
		send_vector(DataMax, DataMin, data_t'(-1));
		send_vector(DataMax, DataMin, '0);
		send_vector(data_t'(1), DataMax, DataMin);
	endtask

	task automatic test_rounding();
		drain();
		// tiny weights: negative products must round toward minus infinity
		write_reg(RegSliceLen, 2);
		set_coeffs(data_t'(1), data_t'(-1), data_t'(32'sh0000_8000));
		send_vector(data_t'(-1), data_t'(1), data_t'(-65537));
		send_vector(data_t'(-3), data_t'(65535), data_t'(32'sh0001_8001));
		send_vector(data_t'(7), data_t'(-7), data_t'(-65536));
		send_vector(data_t'(-2), data_t'(2), data_t'(-1));
		send_vector(data_t'(-65535), data_t'(1), data_t'(3));
		send_vector(data_t'(-131073), data_t'(-1), data_t'(-5));
	endtask

	task automatic test_length_limits();
		drain();
		set_coeffs(random_word(), random_word(), random_word());
		write_reg(RegSliceLen, {21'($urandom), 11'd0});
		stream_vectors(1);
		finish_tensor();
		drain();
		// beyond the memory depth, clipped to full depth; the first slice writes every running sum
		write_reg(RegSliceLen, {21'($urandom), 11'h7FF});
		stream_vectors(MaxVectors);
		drain();
		// short slices close the tensor
		write_reg(RegSliceLen, 1);
		finish_tensor();
	endtask

	task automatic test_len_change_mid_tensor();
		drain();
		set_coeffs(random_word(), random_word(), random_word());
		write_reg(RegSliceLen, 4);
		stream_vectors(2);
		drain();
		write_reg(RegSliceLen, 8);
		finish_tensor();
		drain();
		stream_vectors(5);
		drain();
		// position already past the new end, so the next vector closes the slice
		write_reg(RegSliceLen, 3);
		finish_tensor();
		drain();
		write_reg(RegSliceLen, 4);
		stream_vectors(10);
		drain();
		write_reg(RegSliceLen, 2);
		finish_tensor();
	endtask

	task automatic test_output_stall();
		drain();
		send_idle = 1'b0;
		recv_idle = 1'b0;
		set_coeffs(random_word(), random_word(), random_word());
		write_reg(RegSliceLen, 4);
		hold_left = StallHold;
		stream_vectors(48);
		send_idle = 1'b1;
		recv_idle = 1'b1;
	endtask

	task automatic test_random_tensors();
		int unsigned start;
		start = items_sent;
		while (items_sent - start < RandomItems) begin
			drain();
			send_idle = ($urandom_range(0, 3) != 0);
			recv_idle = ($urandom_range(0, 3) != 0);
			set_coeffs(random_word(), random_word(), random_word());
			write_reg(RegSliceLen, random_len());
			repeat ($urandom_range(1, 4)) begin
				stream_vectors(1);
				finish_tensor();
			end
		end
	endtask

	// result checker
	always @(posedge clk) begin
		result_t want;
		if (res_if.valid && res_if.ready) begin
			res_seen = 1'b1;
			if (pending_results.size() == 0) begin
				report_error($sformatf("unexpected result %h %h %h last %b", res_if.out_x,
					res_if.out_y, res_if.out_z, res_if.last_of_tensor));
			end else begin
				want = pending_results.pop_front();
				compare_field("out_x", res_if.out_x, want.x);
				compare_field("out_y", res_if.out_y, want.y);
				compare_field("out_z", res_if.out_z, want.z);
				compare_field("last_of_tensor", {31'b0, res_if.last_of_tensor}, {31'b0, want.last});
			end
		end
	end

	// result receiver: random stall after each transaction when recv_idle is set, long hold on request
	initial begin
		int unsigned stall_left;
		stall_left = 0;
		res_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (res_seen) begin
				res_seen = 1'b0;
				stall_left = recv_idle ? $urandom_range(0, 12) : 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_if.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				res_if.ready <= 1'b0;
			end else begin
				res_if.ready <= 1'b1;
			end
		end
	end

	initial begin
		int unsigned quiet;
		quiet = 0;
		@(posedge arst_n);
		while (quiet < WatchdogLimit) begin
			@(posedge clk);
			if ((vec_if.valid && vec_if.ready) || (res_if.valid && res_if.ready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("watchdog: no transaction for %0d cycles", quiet);
		$display("FAILED: results differ");
		$finish;
	end

	initial begin
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_idx       = '0;
		cfg_wdata     = '0;
		vec_if.valid  = 1'b0;
		vec_if.comp_x = '0;
		vec_if.comp_y = '0;
		vec_if.comp_z = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_state();
		test_extremes();
		test_rounding();
		test_length_limits();
		test_len_change_mid_tensor();
		test_output_stall();
		test_random_tensors();
		drain();
		repeat (20) @(posedge clk);

		if (mismatches == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
